[rtl/float32_fixed_sign_magnitude_convert_core_assert.svh]
// Assertion macros shared by the converter checker.
`ifndef FLOAT32_FIXED_SIGN_MAGNITUDE_CONVERT_CORE_ASSERT_SVH
`define FLOAT32_FIXED_SIGN_MAGNITUDE_CONVERT_CORE_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define FFC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FFC_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/ffc_pkg.sv]
// Shared constants and types of the float and fixed converter.
`timescale 1ns / 1ps
package ffc_pkg;
  localparam int EXP_BITS  = 8;
  localparam int MANT_BITS = 23;
  localparam int EXP_BIAS  = 127;
  localparam logic CMD_TO_FIXED = 1'b0;
  localparam logic CMD_TO_FLOAT = 1'b1;
  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
  } ffc_result_t;
endpackage

[rtl/ffc_to_fixed.sv]
// Float to sign-magnitude fixed conversion with truncation and saturation.
`timescale 1ns / 1ps
module ffc_to_fixed import ffc_pkg::*; #(
  parameter int INT_BITS  = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic [31:0]  word_i,
  output ffc_result_t  res_o
);
  localparam int MAG_BITS = (INT_BITS + FRAC_BITS > 31) ? 31 : INT_BITS + FRAC_BITS;
  localparam logic [31:0] MAG_MAX = 32'((64'd1 << MAG_BITS) - 64'd1);
  localparam int SH_OFF = FRAC_BITS - MANT_BITS - EXP_BIAS;

  logic          sign;
  logic [7:0]    ex;
  logic [23:0]   sig;
  logic signed [9:0] sh;
  logic [63:0]   mag;
  logic          sat;

  always_comb begin
    sign = word_i[31];
    ex   = word_i[30:23];
    sig  = {1'b1, word_i[22:0]};
    sh   = $signed({2'b00, ex}) + 10'(SH_OFF);
    if (sh >= 0) mag = {40'd0, sig} << sh[5:0];
    else if (sh <= -64) mag = '0;
    else mag = {40'd0, sig} >> 6'(-sh);
    sat = (ex == 8'hFF) || ($signed({2'b00, ex}) - 10'sd127 >= 10'(INT_BITS))
          || (mag > {32'd0, MAG_MAX});
    res_o.ovf = 1'b0;
    if (ex == 8'd0) res_o.word = '0;
    else if (sat) begin
      res_o.word = {sign, 31'd0} | MAG_MAX;
      res_o.ovf  = 1'b1;
    end else if (mag == 64'd0) res_o.word = '0;
    else res_o.word = {sign, 31'd0} | mag[31:0];
  end
endmodule

[rtl/ffc_to_float.sv]
// Sign-magnitude fixed to float conversion with truncated mantissa.
`timescale 1ns / 1ps
module ffc_to_float import ffc_pkg::*; #(
  parameter int INT_BITS  = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);
  localparam int MAG_BITS = (INT_BITS + FRAC_BITS > 31) ? 31 : INT_BITS + FRAC_BITS;
  localparam logic [31:0] MAG_MASK = 32'((64'd1 << MAG_BITS) - 64'd1);

  logic [31:0] mag;
  logic [4:0]  p;
  logic [54:0] norm;
  logic [7:0]  ex;

  always_comb begin
    mag = word_i & MAG_MASK;
    p = '0;
    for (int i = 1; i < 31; i++) if (mag[i]) p = 5'(i);
    // Place the leading one at bit 54 and take the 23 bits below it.
    norm = {23'd0, mag} << (5'd30 - p);
    norm = norm << 24;
    ex = 8'(int'(p) - FRAC_BITS + EXP_BIAS);
    if (mag == 32'd0) word_o = '0;
    else word_o = {word_i[31], ex, norm[53:31]};
  end
endmodule

[rtl/float32_fixed_sign_magnitude_convert_core.sv]
// Top level of the two-way float32 and sign-magnitude fixed converter.
`timescale 1ns / 1ps
// out_valid rises once the input has passed the input register and then the result register.
// Throughput: one transaction per cycle unless stalled; critical path: leading-one search, shift.
// The result register acts as an output stage, so the next input is taken while it waits.
// Reset: synchronous, active low; it clears only the valid flags, payload registers keep data.
module float32_fixed_sign_magnitude_convert_core import ffc_pkg::*; #(
  parameter int INT_BITS  = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_operand_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_word,
  output logic        out_overflow
);
  logic        in_vld_r, in_vld_nxt;
  logic        cmd_r;
  logic [31:0] opw_r;
  logic        out_vld_r, out_vld_nxt;
  ffc_result_t res_r, fix_res, res_nxt;
  logic [31:0] flt_word;
  logic        adv;

  ffc_to_fixed #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_fix (
    .word_i(opw_r), .res_o(fix_res));
  ffc_to_float #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_flt (
    .word_i(opw_r), .word_o(flt_word));

  // The stage advances when the result register is free or being emptied.
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    res_nxt = (cmd_r == CMD_TO_FLOAT) ? ffc_result_t'{word: flt_word, ovf: 1'b0} : fix_res;
    in_vld_nxt  = in_ready ? in_valid : in_vld_r;
    out_vld_nxt = adv ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_ready && in_valid) begin
      cmd_r <= in_command;
      opw_r <= in_operand_word;
    end
    if (adv && in_vld_r) res_r <= res_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_result_word = res_r.word;
  assign out_overflow    = res_r.ovf;
endmodule

[rtl/ffc_checker.sv]
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`include "float32_fixed_sign_magnitude_convert_core_assert.svh"
module ffc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_word,
  input logic        out_overflow
);
  // A stalled result keeps its payload.
  `FFC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_result_word) && out_valid)
  // With no result pending the block always takes input.
  `FFC_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready)
  // An input accepted while the output is free or draining is followed by out_valid later.
  `FFC_ASSERT_NXT(a_flow, clk, rst_n, in_valid && in_ready && (!out_valid || out_ready), ##1 out_valid)
  // Saturation always carries a nonzero magnitude.
  `FFC_ASSERT_IMP(a_sat, clk, rst_n, out_valid && out_overflow, out_result_word[30:0] != 31'd0)
endmodule

bind float32_fixed_sign_magnitude_convert_core ffc_checker u_ffc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_word(out_result_word), .out_overflow(out_overflow));
